### src/nor_flash_command_sequencer_core_defines.svh
// assertion helpers shared by the sequencer modules
`ifndef NOR_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define NFCS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NFCS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### src/nfcs_pkg.sv
`timescale 1ns / 1ps
package nfcs_pkg;

	localparam int BUFFER_WORDS = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] REQ_READ_ID = 3'd0;
	localparam logic [2:0] REQ_SECTOR_ERASE = 3'd1;
	localparam logic [2:0] REQ_CHIP_ERASE = 3'd2;
	localparam logic [2:0] REQ_PROGRAM = 3'd3;
	localparam logic [2:0] REQ_BUF_BEGIN = 3'd4;
	localparam logic [2:0] REQ_BUF_DATA = 3'd5;
	localparam logic [2:0] REQ_POLL = 3'd6;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_ONGOING = 3'd0;
	localparam logic [2:0] ST_SUCCESS = 3'd1;
	localparam logic [2:0] ST_ERROR = 3'd2;
	localparam logic [2:0] ST_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_REJECTED = 3'd4;

	localparam logic [1:0] REG_PROGRAM_TO = 2'd0;
	localparam logic [1:0] REG_SECTOR_TO = 2'd1;
	localparam logic [1:0] REG_CHIP_TO = 2'd2;

	localparam logic [22:0] CMD_ADDR1 = 23'h000AAA;
	localparam logic [22:0] CMD_ADDR2 = 23'h000554;
	localparam logic [22:0] ID_ADDR0 = 23'h000000;
	localparam logic [22:0] ID_ADDR1 = 23'h000002;
	localparam logic [22:0] ID_ADDR2 = 23'h00001C;
	localparam logic [22:0] ID_ADDR3 = 23'h00001E;

	localparam logic [15:0] CMD_UNLOCK1 = 16'h00AA;
	localparam logic [15:0] CMD_UNLOCK2 = 16'h0055;
	localparam logic [15:0] CMD_AUTOSELECT = 16'h0090;
	localparam logic [15:0] CMD_ERASE_SETUP = 16'h0080;
	localparam logic [15:0] CMD_SECTOR_ERASE = 16'h0030;
	localparam logic [15:0] CMD_CHIP_ERASE = 16'h0010;
	localparam logic [15:0] CMD_PROGRAM = 16'h00A0;
	localparam logic [15:0] CMD_BUF_LOAD = 16'h0025;
	localparam logic [15:0] CMD_BUF_CONFIRM = 16'h0029;

	localparam int DQ6_BIT = 6;
	localparam int DQ5_BIT = 5;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LOADING = 5'b00010,
		PH_WAIT_HIGH = 5'b00100,
		PH_WAIT_LOW = 5'b01000,
		PH_TOGGLE = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		OP_READ_ID,
		OP_SECTOR_ERASE,
		OP_CHIP_ERASE,
		OP_PROGRAM,
		OP_BUF_BEGIN,
		OP_BUF_DATA,
		OP_BUF_LAST,
		OP_STATUS
	} op_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [22:0] target_address;
		logic [15:0] write_word;
		logic [4:0] buffer_count;
		logic ready_pin;
		logic [15:0] first_read;
		logic [15:0] second_read;
	} req_t;

	typedef struct packed {
		logic [1:0] cycle_kind;
		logic [22:0] bus_address;
		logic [15:0] bus_data;
		logic [2:0] status;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [23:0] prog_timeout;
		logic [23:0] sector_erase_timeout;
		logic [23:0] chip_erase_timeout;
	} cfg_t;

	typedef struct packed {
		op_t op;
		logic [22:0] addr;
		logic [15:0] data;
		logic [22:0] base;
		logic [2:0] status;
	} desc_t;

	typedef struct packed {
		logic full;
		logic valid;
	} qstat_t;

	function automatic logic [2:0] beat_total(input op_t op);
		logic [2:0] n;
		case (op)
			OP_READ_ID: n = 3'd7;
			OP_SECTOR_ERASE: n = 3'd6;
			OP_CHIP_ERASE: n = 3'd6;
			OP_PROGRAM: n = 3'd4;
			OP_BUF_BEGIN: n = 3'd4;
			OP_BUF_LAST: n = 3'd2;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic rsp_t build_beat(input desc_t d, input logic [2:0] step);
		rsp_t r;
		r.cycle_kind = KIND_WRITE;
		r.bus_address = CMD_ADDR1;
		r.bus_data = 16'h0000;
		r.status = ST_ONGOING;
		r.last = (step == beat_total(d.op) - 3'd1);
		case (d.op)
			OP_READ_ID: begin
				case (step)
					3'd0: r.bus_data = CMD_UNLOCK1;
					3'd1: begin
						r.bus_address = CMD_ADDR2;
						r.bus_data = CMD_UNLOCK2;
					end
					3'd2: r.bus_data = CMD_AUTOSELECT;
					3'd3: begin
						r.cycle_kind = KIND_READ;
						r.bus_address = ID_ADDR0;
					end
					3'd4: begin
						r.cycle_kind = KIND_READ;
						r.bus_address = ID_ADDR1;
					end
					3'd5: begin
						r.cycle_kind = KIND_READ;
						r.bus_address = ID_ADDR2;
					end
					default: begin
						r.cycle_kind = KIND_READ;
						r.bus_address = ID_ADDR3;
					end
				endcase
			end
			OP_SECTOR_ERASE, OP_CHIP_ERASE: begin
				case (step)
					3'd0, 3'd3: r.bus_data = CMD_UNLOCK1;
					3'd1, 3'd4: begin
						r.bus_address = CMD_ADDR2;
						r.bus_data = CMD_UNLOCK2;
					end
					3'd2: r.bus_data = CMD_ERASE_SETUP;
					default: begin
						if (d.op == OP_SECTOR_ERASE) begin
							r.bus_address = d.addr;
							r.bus_data = CMD_SECTOR_ERASE;
						end else begin
							r.bus_data = CMD_CHIP_ERASE;
						end
					end
				endcase
			end
			OP_PROGRAM, OP_BUF_BEGIN: begin
				case (step)
					3'd0: r.bus_data = CMD_UNLOCK1;
					3'd1: begin
						r.bus_address = CMD_ADDR2;
						r.bus_data = CMD_UNLOCK2;
					end
					3'd2: begin
						if (d.op == OP_PROGRAM) begin
							r.bus_data = CMD_PROGRAM;
						end else begin
							r.bus_address = d.addr;
							r.bus_data = CMD_BUF_LOAD;
						end
					end
					default: begin
						r.bus_address = d.addr;
						r.bus_data = d.data;
					end
				endcase
			end
			OP_BUF_DATA, OP_BUF_LAST: begin
				if (step == 3'd0) begin
					r.bus_address = d.addr;
					r.bus_data = d.data;
				end else begin
					r.bus_address = d.base;
					r.bus_data = CMD_BUF_CONFIRM;
				end
			end
			default: begin
				r.cycle_kind = KIND_STATUS;
				r.bus_address = 23'd0;
				r.status = d.status;
			end
		endcase
		return r;
	endfunction

endpackage

### src/nfcs_queue.sv
`timescale 1ns / 1ps
`include "nor_flash_command_sequencer_core_defines.svh"
module nfcs_queue
	import nfcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input desc_t push_desc,
	input logic pop,
	output desc_t head_desc,
	output qstat_t qstat
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.valid = (count_q != '0);
	assign qstat.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`NFCS_ASSERT_ALWAYS(a_queue_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
	`NFCS_ASSERT_IMP(a_queue_no_overflow, push && !pop, !qstat.full, "push into full queue")

endmodule

### src/nfcs_front.sv
`timescale 1ns / 1ps
`include "nor_flash_command_sequencer_core_defines.svh"
module nfcs_front
	import nfcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input req_t in_item,
	input cfg_t cfg,
	input qstat_t qstat,
	output logic push,
	output desc_t push_desc
);

	phase_t phase_q;
	phase_t phase_d;
	logic [23:0] budget_q;
	logic [23:0] budget_d;
	logic [23:0] loaded_q;
	logic [23:0] loaded_d;
	logic parity_q;
	logic parity_d;
	logic [22:0] base_q;
	logic [22:0] base_d;
	logic [22:0] next_q;
	logic [22:0] next_d;
	logic [4:0] left_q;
	logic [4:0] left_d;

	logic same;
	logic waiting;
	logic budget_zero;
	logic [4:0] cnt;

	assign push = in_valid && !qstat.full;
	assign same = (in_item.first_read[DQ6_BIT] == in_item.second_read[DQ6_BIT]);
	assign budget_zero = (budget_q == 24'd0);
	assign cnt = in_item.buffer_count;
	assign waiting = (phase_q == PH_WAIT_HIGH) ? in_item.ready_pin : !in_item.ready_pin;

	always_comb begin
		phase_d = phase_q;
		budget_d = budget_q;
		loaded_d = loaded_q;
		parity_d = parity_q;
		base_d = base_q;
		next_d = next_q;
		left_d = left_q;
		push_desc.op = OP_STATUS;
		push_desc.addr = in_item.target_address;
		push_desc.data = in_item.write_word;
		push_desc.base = base_q;
		push_desc.status = ST_REJECTED;
		case (in_item.req_type)
			REQ_POLL: begin
				if (phase_q inside {PH_WAIT_HIGH, PH_WAIT_LOW}) begin
					push_desc.status = ST_ONGOING;
					if (waiting && !budget_zero) begin
						budget_d = budget_q - 24'd1;
					end else begin
						budget_d = loaded_q;
						parity_d = 1'b0;
						phase_d = (phase_q == PH_WAIT_HIGH) ? PH_WAIT_LOW : PH_TOGGLE;
					end
				end else if (phase_q == PH_TOGGLE) begin
					if (!parity_q) begin
						if (budget_zero) begin
							phase_d = PH_IDLE;
							push_desc.status = ST_TIMEOUT;
						end else begin
							budget_d = budget_q - 24'd1;
							if (same) begin
								phase_d = PH_IDLE;
								push_desc.status = ST_SUCCESS;
							end else begin
								parity_d = 1'b1;
								push_desc.status = ST_ONGOING;
							end
						end
					end else begin
						parity_d = 1'b0;
						if (same) begin
							phase_d = PH_IDLE;
							push_desc.status = ST_SUCCESS;
						end else if (in_item.first_read[DQ5_BIT]) begin
							phase_d = PH_IDLE;
							push_desc.status = ST_ERROR;
						end else if (budget_zero) begin
							phase_d = PH_IDLE;
							push_desc.status = ST_TIMEOUT;
						end else begin
							push_desc.status = ST_ONGOING;
						end
					end
				end
			end
			REQ_BUF_DATA: begin
				if (phase_q == PH_LOADING && left_q != 5'd0) begin
					push_desc.addr = next_q;
					next_d = next_q + 23'd2;
					left_d = left_q - 5'd1;
					if (left_q == 5'd1) begin
						push_desc.op = OP_BUF_LAST;
						loaded_d = cfg.prog_timeout;
						budget_d = cfg.prog_timeout;
						parity_d = 1'b0;
						phase_d = PH_WAIT_HIGH;
					end else begin
						push_desc.op = OP_BUF_DATA;
					end
				end
			end
			REQ_READ_ID: begin
				if (phase_q == PH_IDLE) begin
					push_desc.op = OP_READ_ID;
				end
			end
			REQ_SECTOR_ERASE: begin
				if (phase_q == PH_IDLE) begin
					push_desc.op = OP_SECTOR_ERASE;
					loaded_d = cfg.sector_erase_timeout;
					budget_d = cfg.sector_erase_timeout;
					parity_d = 1'b0;
					phase_d = PH_WAIT_HIGH;
				end
			end
			REQ_CHIP_ERASE: begin
				if (phase_q == PH_IDLE) begin
					push_desc.op = OP_CHIP_ERASE;
					loaded_d = cfg.chip_erase_timeout;
					budget_d = cfg.chip_erase_timeout;
					parity_d = 1'b0;
					phase_d = PH_WAIT_HIGH;
				end
			end
			REQ_PROGRAM: begin
				if (phase_q == PH_IDLE) begin
					push_desc.op = OP_PROGRAM;
					loaded_d = cfg.prog_timeout;
					budget_d = cfg.prog_timeout;
					parity_d = 1'b0;
					phase_d = PH_WAIT_HIGH;
				end
			end
			REQ_BUF_BEGIN: begin
				if (phase_q == PH_IDLE && cnt != 5'd0 && cnt <= 5'(BUFFER_WORDS)) begin
					push_desc.op = OP_BUF_BEGIN;
					push_desc.data = {11'd0, cnt - 5'd1};
					base_d = in_item.target_address;
					next_d = in_item.target_address;
					left_d = cnt;
					phase_d = PH_LOADING;
				end
			end
			default: begin
				push_desc.op = OP_STATUS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			budget_q <= '0;
			loaded_q <= '0;
			parity_q <= 1'b0;
			base_q <= '0;
			next_q <= '0;
			left_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			budget_q <= budget_d;
			loaded_q <= loaded_d;
			parity_q <= parity_d;
			base_q <= base_d;
			next_q <= next_d;
			left_q <= left_d;
		end
	end

	`NFCS_ASSERT_IMP(a_front_loading_left, phase_q == PH_LOADING, left_q != 5'd0, "open buffer load with no words left")
	`NFCS_ASSERT_IMP(a_front_parity_toggle, parity_q, phase_q == PH_TOGGLE, "pair parity set outside toggle check")

endmodule

### src/nfcs_back.sv
`timescale 1ns / 1ps
`include "nor_flash_command_sequencer_core_defines.svh"
module nfcs_back
	import nfcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input qstat_t qstat,
	input desc_t head_desc,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output rsp_t out_item
);

	logic [2:0] step_q;
	logic out_valid_q;
	rsp_t out_q;
	rsp_t beat;
	logic load;

	assign beat = build_beat(head_desc, step_q);
	assign load = qstat.valid && (!out_valid_q || !out_stall);
	assign pop = load && beat.last;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= beat.last ? 3'd0 : step_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`NFCS_ASSERT_IMP(a_back_mid_sequence, step_q != 3'd0, qstat.valid, "sequence lost its descriptor")
	`NFCS_ASSERT_IMP(a_back_status_last, out_valid_q && out_q.cycle_kind == KIND_STATUS, out_q.last, "status beat not final")

endmodule

### src/nor_flash_command_sequencer_core.sv
// first beat: a request is queued, then its beat is registered at the output
// throughput: one beat per cycle while out_stall is low; a request has 1 to 7 beats
// (read id 7, erase 6, program and buffer begin 4, last buffer word 2, others 1),
// set by the beat sequencer that expands each queued request
// reset: asynchronous active low; idle phase, empty queue, timeouts at their defaults
`timescale 1ns / 1ps
module nor_flash_command_sequencer_core
	import nfcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input req_t in_item,
	output logic out_valid,
	input logic out_stall,
	output rsp_t out_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	qstat_t qstat;
	desc_t push_desc;
	desc_t head_desc;
	logic push;
	logic pop;
	logic reg_wr;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign in_stall = qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prog_timeout <= 24'd65535;
			cfg_q.sector_erase_timeout <= 24'hFFFFFF;
			cfg_q.chip_erase_timeout <= 24'hFFFFFF;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_PROGRAM_TO: cfg_q.prog_timeout <= pwdata[23:0];
				REG_SECTOR_TO: cfg_q.sector_erase_timeout <= pwdata[23:0];
				REG_CHIP_TO: cfg_q.chip_erase_timeout <= pwdata[23:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PROGRAM_TO: prdata = {8'd0, cfg_q.prog_timeout};
			REG_SECTOR_TO: prdata = {8'd0, cfg_q.sector_erase_timeout};
			REG_CHIP_TO: prdata = {8'd0, cfg_q.chip_erase_timeout};
			default: prdata = 32'd0;
		endcase
	end

	nfcs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_item(in_item),
		.cfg(cfg_q),
		.qstat(qstat),
		.push(push),
		.push_desc(push_desc)
	);

	nfcs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_desc(push_desc),
		.pop(pop),
		.head_desc(head_desc),
		.qstat(qstat)
	);

	nfcs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.head_desc(head_desc),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

endmodule
